FILE: design/soa_pkg.sv
package soa_pkg;

   // Default sizes of the pool
   localparam int NUM_SLABS_DEF = 16;
   localparam int MAX_OBJS_DEF  = 64;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int SLAB_W   = 4;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 32;
   localparam int CFG_W    = 7;
   // Wide enough for any slab or slot number in the parameter range
   localparam int EXT_W    = 9;

   localparam logic [CFG_W-1:0] OBJS_RESET = 7'd64;
   localparam int               MIN_OBJS   = 4;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_RELALL = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   // Result statuses
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

   // Datapath commands
   localparam logic [3:0] CMD_NONE        = 4'd0;
   localparam logic [3:0] CMD_LOAD        = 4'd1;
   localparam logic [3:0] CMD_SCAN_NEXT   = 4'd2;
   localparam logic [3:0] CMD_SCAN_PICK   = 4'd3;
   localparam logic [3:0] CMD_BUILD       = 4'd4;
   localparam logic [3:0] CMD_ACTIVATE    = 4'd5;
   localparam logic [3:0] CMD_POP_READ    = 4'd6;
   localparam logic [3:0] CMD_POP_COMMIT  = 4'd7;
   localparam logic [3:0] CMD_UNLINK      = 4'd8;
   localparam logic [3:0] CMD_FREE_COMMIT = 4'd9;
   localparam logic [3:0] CMD_PUSH_LINK   = 4'd10;
   localparam logic [3:0] CMD_PUSH_HEAD   = 4'd11;
   localparam logic [3:0] CMD_CLEAR       = 4'd12;
   localparam logic [3:0] CMD_FINISH      = 4'd13;

   typedef struct packed {
      logic [3:0]          code;
      logic [STATUS_W-1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            head_empty;
      logic            scan_free;
      logic            scan_last;
      logic            build_last;
      logic            pop_empty;
      logic            pop_fills;
      logic            free_bad;
      logic            free_empties;
      logic            free_full_slab;
      logic            out_free;
   } dp_stat_type;

endpackage

FILE: design/soa_req_if.sv
interface soa_req_if
   import soa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [SLAB_W-1:0] slab_index;
   logic [SLOT_W-1:0] slot_index;

   modport source (output valid, opcode, slab_index, slot_index, input ready);
   modport sink   (input valid, opcode, slab_index, slot_index, output ready);
endinterface

FILE: design/soa_rsp_if.sv
interface soa_rsp_if
   import soa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLAB_W-1:0]   granted_slab;
   logic [SLOT_W-1:0]   granted_slot;
   logic                slab_created;
   logic                slab_released;
   logic [CNT_W-1:0]    alloc_total;
   logic [CNT_W-1:0]    free_total;

   modport source (output valid, status, granted_slab, granted_slot, slab_created,
                   slab_released, alloc_total, free_total, input ready);
   modport sink   (input valid, status, granted_slab, granted_slot, slab_created,
                   slab_released, alloc_total, free_total, output ready);
endinterface

FILE: design/slab_object_allocator_top.sv
// Slab object allocator. One request item gives one response item. The block
// takes a request only when its sequencer is idle; the response sits in an
// output register, so a new request is taken while an older response waits.
// An allocate from a partial slab steps through decode, link read, commit and
// result, with an unlink before the result when the slab fills and leaves the
// partial list. An allocate that must open a slab first adds a scan of one
// slab per cycle up to the lowest free slab, a build of its free list slot by
// slot (the configured slot count), and activate and push head to link it in.
// A free steps through decode, commit and result, adding an unlink when its
// slab empties, or push link and push head when a full slab regains a slot.
// Release all clears every slab in turn. The slot link memory has one port.
// The slot count register is only taken while no slab is live; no read-back.
module slab_object_allocator_top
   import soa_pkg::*;
#(
   parameter int NUM_SLABS = NUM_SLABS_DEF,
   parameter int MAX_OBJS  = MAX_OBJS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   soa_req_if.sink          req_chan,
   soa_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        idle;
   logic        req_fire;

   assign req_chan.ready = idle;
   assign req_fire       = req_chan.valid && idle;

   soa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .stat     (stat),
      .cmd      (cmd),
      .idle     (idle)
   );

   soa_datapath #(
      .NUM_SLABS (NUM_SLABS),
      .MAX_OBJS  (MAX_OBJS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_chan.opcode),
      .req_slab_index    (req_chan.slab_index),
      .req_slot_index    (req_chan.slot_index),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_granted_slab  (rsp_chan.granted_slab),
      .rsp_granted_slot  (rsp_chan.granted_slot),
      .rsp_slab_created  (rsp_chan.slab_created),
      .rsp_slab_released (rsp_chan.slab_released),
      .rsp_alloc_total   (rsp_chan.alloc_total),
      .rsp_free_total    (rsp_chan.free_total)
   );

   // Sequencer is busy in the cycle after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request taken while previous item in flight");

   // A rejected free never carries a grant or a new slab
   a_badfree_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == ST_BADFREE) |->
      (rsp_chan.granted_slab == '0) && (rsp_chan.granted_slot == '0)
      && !rsp_chan.slab_created && !rsp_chan.slab_released)
      else $error("bad free reported with side effects");

   // Out of memory never releases a slab
   a_oom_no_release: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == ST_OOM) |-> !rsp_chan.slab_released)
      else $error("out of memory reported with a release");

endmodule

FILE: design/soa_ctrl.sv
module soa_ctrl
   import soa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        idle
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_SCAN      = 4'd2;
   localparam logic [3:0] S_BUILD     = 4'd3;
   localparam logic [3:0] S_ACTIVATE  = 4'd4;
   localparam logic [3:0] S_PUSH_LINK = 4'd5;
   localparam logic [3:0] S_PUSH_HEAD = 4'd6;
   localparam logic [3:0] S_POP_READ  = 4'd7;
   localparam logic [3:0] S_POP_COMMIT= 4'd8;
   localparam logic [3:0] S_UNLINK    = 4'd9;
   localparam logic [3:0] S_FREE      = 4'd10;
   localparam logic [3:0] S_CLEAR     = 4'd11;
   localparam logic [3:0] S_FINISH    = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [STATUS_W-1:0] res_ff, res_in;

   // Next state and command
   always_comb begin
      state_in       = state_ff;
      res_in         = res_ff;
      cmd.code       = CMD_NONE;
      cmd.rsp_status = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.code = CMD_LOAD;
               res_in   = ST_OK;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_ALLOC:  state_in = stat.head_empty ? S_SCAN : S_POP_READ;
               OP_FREE:   state_in = S_FREE;
               OP_RELALL: state_in = S_CLEAR;
               default:   state_in = S_FINISH;
            endcase
         end
         S_SCAN: begin
            if (stat.scan_free) begin
               cmd.code = CMD_SCAN_PICK;
               state_in = S_BUILD;
            end else if (stat.scan_last) begin
               res_in   = ST_OOM;
               state_in = S_FINISH;
            end else begin
               cmd.code = CMD_SCAN_NEXT;
            end
         end
         S_BUILD: begin
            cmd.code = CMD_BUILD;
            if (stat.build_last) state_in = S_ACTIVATE;
         end
         S_ACTIVATE: begin
            cmd.code = CMD_ACTIVATE;
            state_in = S_PUSH_HEAD;
         end
         S_PUSH_LINK: begin
            cmd.code = CMD_PUSH_LINK;
            state_in = S_PUSH_HEAD;
         end
         S_PUSH_HEAD: begin
            cmd.code = CMD_PUSH_HEAD;
            state_in = (stat.op == OP_ALLOC) ? S_POP_READ : S_FINISH;
         end
         S_POP_READ: begin
            if (stat.pop_empty) begin
               res_in   = ST_OOM;
               state_in = S_FINISH;
            end else begin
               cmd.code = CMD_POP_READ;
               state_in = S_POP_COMMIT;
            end
         end
         S_POP_COMMIT: begin
            cmd.code = CMD_POP_COMMIT;
            state_in = stat.pop_fills ? S_UNLINK : S_FINISH;
         end
         S_UNLINK: begin
            cmd.code = CMD_UNLINK;
            state_in = S_FINISH;
         end
         S_FREE: begin
            if (stat.free_bad) begin
               res_in   = ST_BADFREE;
               state_in = S_FINISH;
            end else begin
               cmd.code = CMD_FREE_COMMIT;
               if (stat.free_empties)
                  state_in = stat.free_full_slab ? S_FINISH : S_UNLINK;
               else
                  state_in = stat.free_full_slab ? S_PUSH_LINK : S_FINISH;
            end
         end
         S_CLEAR: begin
            cmd.code = CMD_CLEAR;
            if (stat.scan_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.code = CMD_FINISH;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= ST_OK;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

endmodule

FILE: design/soa_datapath.sv
module soa_datapath
   import soa_pkg::*;
#(
   parameter int NUM_SLABS = NUM_SLABS_DEF,
   parameter int MAX_OBJS  = MAX_OBJS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [SLAB_W-1:0]   req_slab_index,
   input  logic [SLOT_W-1:0]   req_slot_index,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLAB_W-1:0]   rsp_granted_slab,
   output logic [SLOT_W-1:0]   rsp_granted_slot,
   output logic                rsp_slab_created,
   output logic                rsp_slab_released,
   output logic [CNT_W-1:0]    rsp_alloc_total,
   output logic [CNT_W-1:0]    rsp_free_total
);

   localparam int SIW       = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
   localparam int SW        = $clog2(NUM_SLABS + 1);
   localparam int OIW       = $clog2(MAX_OBJS);
   localparam int OW        = $clog2(MAX_OBJS + 1);
   localparam int MEM_DEPTH = NUM_SLABS * (2 ** OIW);
   localparam logic [SW-1:0]  NO_SLAB  = SW'(NUM_SLABS);
   localparam logic [OW-1:0]  LIST_END = OW'(MAX_OBJS);
   localparam logic [SIW-1:0] LAST_SLAB = SIW'(NUM_SLABS - 1);

   // Control state
   logic [NUM_SLABS-1:0] live_ff, live_in, full_ff, full_in;
   logic [SW-1:0]        head_ff, head_in, live_cnt_ff, live_cnt_in;
   logic [CNT_W-1:0]     alloc_ff, alloc_in, free_ff, free_in;
   logic [CFG_W-1:0]     objs_ff, objs_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Per-slab tables and slot link memory
   logic [OW-1:0] used_ff      [NUM_SLABS];
   logic [OW-1:0] free_head_ff [NUM_SLABS];
   logic [SW-1:0] next_ff      [NUM_SLABS];
   logic [SW-1:0] prev_ff      [NUM_SLABS];
   logic [OW-1:0] link_mem     [MEM_DEPTH];
   logic [OW-1:0] rdata_ff;

   // Working registers
   logic [OP_W-1:0]   op_ff;
   logic [SLAB_W-1:0] fslab_ff;
   logic [SLOT_W-1:0] fslot_ff;
   logic [SIW-1:0]    cur_ff, scan_ff;
   logic [OIW-1:0]    bld_ff, slot_ff;
   logic              created_ff, released_ff;
   logic [SIW-1:0]    gslab_ff;
   logic [OIW-1:0]    gslot_ff;

   // Result register
   logic [STATUS_W-1:0] out_status_ff;
   logic [SLAB_W-1:0]   out_slab_ff;
   logic [SLOT_W-1:0]   out_slot_ff;
   logic                out_created_ff, out_released_ff;
   logic [CNT_W-1:0]    out_alloc_ff, out_free_ff;

   logic [EXT_W-1:0] objs_ext, cap_ext, fslab_ext, fslot_ext, gslab_ext, gslot_ext;
   logic [OW-1:0]    cap, bld_next, build_data, fslot_ow;
   logic [SIW-1:0]   head_idx, fidx;
   logic [OIW-1:0]   fslot_idx, pop_slot;
   logic [SW-1:0]    lnk_p, lnk_n;
   logic             out_free;

   // Effective slots per slab, saturated into the legal range
   assign objs_ext = EXT_W'(objs_ff);
   always_comb begin
      if (objs_ext < EXT_W'(MIN_OBJS))      cap_ext = EXT_W'(MIN_OBJS);
      else if (objs_ext > EXT_W'(MAX_OBJS)) cap_ext = EXT_W'(MAX_OBJS);
      else                                  cap_ext = objs_ext;
   end
   assign cap = cap_ext[OW-1:0];

   assign fslab_ext = EXT_W'(fslab_ff);
   assign fslot_ext = EXT_W'(fslot_ff);
   assign fidx      = fslab_ext[SIW-1:0];
   assign fslot_idx = fslot_ext[OIW-1:0];
   assign fslot_ow  = fslot_ext[OW-1:0];
   assign head_idx  = head_ff[SIW-1:0];
   assign pop_slot  = free_head_ff[head_idx][OIW-1:0];
   assign bld_next  = OW'(bld_ff) + OW'(1);
   assign build_data = (bld_next < cap) ? bld_next : LIST_END;
   assign lnk_p     = prev_ff[cur_ff];
   assign lnk_n     = next_ff[cur_ff];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Status towards the controller
   always_comb begin
      stat.op             = op_ff;
      stat.head_empty     = (head_ff >= NO_SLAB);
      stat.scan_free      = !live_ff[scan_ff];
      stat.scan_last      = (scan_ff == LAST_SLAB);
      stat.build_last     = (bld_next >= cap);
      stat.pop_empty      = (free_head_ff[head_idx] >= LIST_END);
      stat.pop_fills      = ((used_ff[cur_ff] + OW'(1)) >= cap);
      stat.free_bad       = (fslab_ext >= EXT_W'(NUM_SLABS)) || (fslot_ext >= EXT_W'(cap))
                            || !live_ff[fidx] || (used_ff[fidx] == '0);
      stat.free_empties   = (used_ff[fidx] == OW'(1));
      stat.free_full_slab = full_ff[fidx];
      stat.out_free       = out_free;
   end

   // Next value of control state
   always_comb begin
      live_in      = live_ff;
      full_in      = full_ff;
      head_in      = head_ff;
      live_cnt_in  = live_cnt_ff;
      alloc_in     = alloc_ff;
      free_in      = free_ff;
      objs_in      = objs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (csr_wr_en && (live_cnt_ff == '0)) objs_in = csr_wr_data;
      case (cmd.code)
         CMD_ACTIVATE: begin
            live_in[cur_ff] = 1'b1;
            full_in[cur_ff] = 1'b0;
            live_cnt_in     = live_cnt_ff + SW'(1);
         end
         CMD_POP_COMMIT: begin
            alloc_in = alloc_ff + CNT_W'(1);
            if (stat.pop_fills) full_in[cur_ff] = 1'b1;
         end
         CMD_UNLINK: begin
            if (lnk_p >= NO_SLAB) head_in = lnk_n;
         end
         CMD_FREE_COMMIT: begin
            free_in = free_ff + CNT_W'(1);
            full_in[fidx] = 1'b0;
            if (stat.free_empties) begin
               live_in[fidx] = 1'b0;
               live_cnt_in   = live_cnt_ff - SW'(1);
            end
         end
         CMD_PUSH_HEAD: head_in = SW'(cur_ff);
         CMD_CLEAR: begin
            live_in[scan_ff] = 1'b0;
            full_in[scan_ff] = 1'b0;
            if (stat.scan_last) begin
               head_in     = NO_SLAB;
               live_cnt_in = '0;
            end
         end
         CMD_FINISH: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         full_ff      <= '0;
         head_ff      <= NO_SLAB;
         live_cnt_ff  <= '0;
         alloc_ff     <= '0;
         free_ff      <= '0;
         objs_ff      <= OBJS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         live_ff      <= live_in;
         full_ff      <= full_in;
         head_ff      <= head_in;
         live_cnt_ff  <= live_cnt_in;
         alloc_ff     <= alloc_in;
         free_ff      <= free_in;
         objs_ff      <= objs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Tables, link memory and working registers
   always_ff @(posedge clock) begin
      case (cmd.code)
         CMD_LOAD: begin
            op_ff       <= req_opcode;
            fslab_ff    <= req_slab_index;
            fslot_ff    <= req_slot_index;
            created_ff  <= 1'b0;
            released_ff <= 1'b0;
            gslab_ff    <= '0;
            gslot_ff    <= '0;
            scan_ff     <= '0;
         end
         CMD_SCAN_NEXT: scan_ff <= scan_ff + SIW'(1);
         CMD_SCAN_PICK: begin
            cur_ff <= scan_ff;
            bld_ff <= '0;
         end
         CMD_BUILD: begin
            link_mem[{cur_ff, bld_ff}] <= build_data;
            bld_ff <= bld_ff + OIW'(1);
         end
         CMD_ACTIVATE: begin
            free_head_ff[cur_ff] <= '0;
            used_ff[cur_ff]      <= '0;
            prev_ff[cur_ff]      <= NO_SLAB;
            next_ff[cur_ff]      <= head_ff;
            created_ff           <= 1'b1;
         end
         CMD_POP_READ: begin
            cur_ff   <= head_idx;
            slot_ff  <= pop_slot;
            rdata_ff <= link_mem[{head_idx, pop_slot}];
         end
         CMD_POP_COMMIT: begin
            free_head_ff[cur_ff] <= rdata_ff;
            used_ff[cur_ff]      <= used_ff[cur_ff] + OW'(1);
            gslab_ff             <= cur_ff;
            gslot_ff             <= slot_ff;
         end
         CMD_UNLINK: begin
            if (lnk_p < NO_SLAB) next_ff[lnk_p[SIW-1:0]] <= lnk_n;
            if (lnk_n < NO_SLAB) prev_ff[lnk_n[SIW-1:0]] <= lnk_p;
         end
         CMD_FREE_COMMIT: begin
            link_mem[{fidx, fslot_idx}] <= free_head_ff[fidx];
            free_head_ff[fidx] <= fslot_ow;
            used_ff[fidx]      <= used_ff[fidx] - OW'(1);
            cur_ff             <= fidx;
            if (stat.free_empties) released_ff <= 1'b1;
         end
         CMD_PUSH_LINK: begin
            prev_ff[cur_ff] <= NO_SLAB;
            next_ff[cur_ff] <= head_ff;
         end
         CMD_PUSH_HEAD: begin
            if (head_ff < NO_SLAB) prev_ff[head_idx] <= SW'(cur_ff);
         end
         CMD_CLEAR: begin
            if (live_ff[scan_ff]) released_ff <= 1'b1;
            scan_ff <= scan_ff + SIW'(1);
         end
         CMD_FINISH: begin
            if (out_free) begin
               out_status_ff   <= cmd.rsp_status;
               out_slab_ff     <= gslab_ext[SLAB_W-1:0];
               out_slot_ff     <= gslot_ext[SLOT_W-1:0];
               out_created_ff  <= created_ff;
               out_released_ff <= released_ff;
               out_alloc_ff    <= alloc_ff;
               out_free_ff     <= free_ff;
            end
         end
         default: ;
      endcase
   end

   assign gslab_ext = EXT_W'(gslab_ff);
   assign gslot_ext = EXT_W'(gslot_ff);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_granted_slab  = out_slab_ff;
   assign rsp_granted_slot  = out_slot_ff;
   assign rsp_slab_created  = out_created_ff;
   assign rsp_slab_released = out_released_ff;
   assign rsp_alloc_total   = out_alloc_ff;
   assign rsp_free_total    = out_free_ff;

endmodule
